[src/jsfe_pkg.sv]
// ----------------------------------------------------------------------------
// jsfe_pkg - shared definitions for the JSON string field extractor
// Result kinds, default sizes and the command word that the front end
// hands to the back end through the queue.
// ----------------------------------------------------------------------------
package jsfe_pkg;

	// Default saturation limit of the per-line byte count.
	localparam int MAX_LEN_DEF = 4095;
	// Default number of commands the queue between front and back can hold.
	localparam int QUEUE_DEPTH_DEF = 4;
	// Data bytes one input byte can produce at most.
	localparam int SLOTS = 4;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int NW = $clog2(SLOTS + 1);
	// Width of the length field on the output.
	localparam int LEN_W = 12;
	// Key character after reset ('e').
	localparam logic [6:0] KEY_RESET = 7'd101;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_FOUND = 2'd1,
		KIND_NONE  = 2'd2
	} kind_t;

	// Everything one accepted input byte produces: zero to SLOTS data
	// bytes, optionally followed by the line status.
	typedef struct packed {
		logic [SLOTS-1:0][7:0] data;
		logic [NW-1:0]         n_data;
		logic                  stat;
		kind_t                 kind;
		logic [LEN_W-1:0]      len;
	} cmd_t;

endpackage

[src/jsfe_front.sv]
// ----------------------------------------------------------------------------
// jsfe_front - byte parser of the JSON string field extractor
// Holds the line state, parses one byte per transfer and builds the command
// of result items that the byte causes.
// ----------------------------------------------------------------------------
module jsfe_front #(
	parameter int MAX_LEN = jsfe_pkg::MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [6:0]        cfg_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tlast,
	input  logic              q_full,
	output logic              cmd_valid,
	output jsfe_pkg::cmd_t    cmd
);

	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam int SUM_W = CNT_W + 1;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	typedef enum logic [9:0] {
		PH_SRCH0     = 10'b00_0000_0001,
		PH_SRCH1     = 10'b00_0000_0010,
		PH_SRCH2     = 10'b00_0000_0100,
		PH_PRECOLON  = 10'b00_0000_1000,
		PH_POSTCOLON = 10'b00_0001_0000,
		PH_VALUE     = 10'b00_0010_0000,
		PH_ESC       = 10'b00_0100_0000,
		PH_HEX       = 10'b00_1000_0000,
		PH_CLOSED    = 10'b01_0000_0000,
		PH_FAIL      = 10'b10_0000_0000
	} phase_t;

	// Line state plus the bytes produced so far for the current transfer.
	typedef struct packed {
		phase_t                          ph;
		logic [15:0]                     cp;
		logic [2:0]                      hc;
		logic [2:0][7:0]                 held;
		logic [jsfe_pkg::SLOTS-1:0][7:0] ob;
		logic [jsfe_pkg::NW-1:0]         on;
	} ctx_t;

	phase_t           ph_q;
	logic [15:0]      cp_q;
	logic [2:0]       hc_q;
	logic [2:0][7:0]  held_q;
	logic [CNT_W-1:0] cnt_q;
	logic [6:0]       key_q;

	ctx_t cur;
	ctx_t body;
	ctx_t tail;
	logic [CNT_W-1:0] cnt_body;
	logic [CNT_W-1:0] cnt_tail;
	logic accept;

	function automatic logic [3:0] hex_nib(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			v = 4'(c - 8'h30);
		end else if (c inside {[8'h61:8'h66]}) begin
			v = 4'(c - 8'h57);
		end else if (c inside {[8'h41:8'h46]}) begin
			v = 4'(c - 8'h37);
		end
		return v;
	endfunction

	function automatic logic is_val(input phase_t ph);
		return (ph == PH_VALUE) || (ph == PH_ESC) || (ph == PH_HEX);
	endfunction

	function automatic ctx_t emit_b(input ctx_t x, input logic [7:0] b);
		ctx_t y;
		y = x;
		if (y.on < jsfe_pkg::NW'(jsfe_pkg::SLOTS)) begin
			y.ob[y.on[jsfe_pkg::SLOT_W-1:0]] = b;
		end
		y.on = y.on + jsfe_pkg::NW'(1);
		return y;
	endfunction

	// Adds the bytes of one transfer to the line count. The count never
	// exceeds MAX_LEN, so one saturating add equals saturating per byte.
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [jsfe_pkg::NW-1:0] n);
		logic [SUM_W-1:0] s;
		s = {1'b0, a} + SUM_W'(n);
		return (s > SUM_W'(MAX_LEN)) ? CNT_W'(MAX_LEN) : s[CNT_W-1:0];
	endfunction

	function automatic ctx_t value_byte(input ctx_t x, input logic [7:0] c);
		ctx_t y;
		y = x;
		case (y.ph)
			PH_VALUE: begin
				if (c == CH_QUOTE) begin
					y.ph = PH_CLOSED;
				end else if (c == CH_BSL) begin
					y.ph = PH_ESC;
				end else begin
					y = emit_b(y, c);
				end
			end
			PH_ESC: begin
				y.ph = PH_VALUE;
				case (c)
					8'h6E: y = emit_b(y, 8'h0A);
					8'h74: y = emit_b(y, 8'h09);
					8'h72: y = emit_b(y, 8'h0D);
					8'h62: y = emit_b(y, 8'h08);
					8'h66: y = emit_b(y, 8'h0C);
					8'h75: begin
						y.ph = PH_HEX;
						y.cp = '0;
						y.hc = '0;
					end
					default: y = emit_b(y, c);
				endcase
			end
			PH_HEX: begin
				if (y.hc < 3'd3) begin
					y.held[y.hc[1:0]] = c;
				end
				y.cp = {y.cp[11:0], hex_nib(c)};
				y.hc = y.hc + 3'd1;
				if (y.hc >= 3'd4) begin
					// Encode the code point as UTF-8, one to three bytes.
					if (y.cp < 16'h0080) begin
						y = emit_b(y, y.cp[7:0]);
					end else if (y.cp < 16'h0800) begin
						y = emit_b(y, 8'hC0 | {3'b000, y.cp[10:6]});
						y = emit_b(y, 8'h80 | {2'b00, y.cp[5:0]});
					end else begin
						y = emit_b(y, 8'hE0 | {4'b0000, y.cp[15:12]});
						y = emit_b(y, 8'h80 | {2'b00, y.cp[11:6]});
						y = emit_b(y, 8'h80 | {2'b00, y.cp[5:0]});
					end
					y.hc = '0;
					y.cp = '0;
					y.ph = PH_VALUE;
				end
			end
			default: ;
		endcase
		return y;
	endfunction

	// End of the buffer: finish a pending escape, replay the bytes of a
	// short \u escape, then close the value or fail the line.
	function automatic ctx_t end_buf(input ctx_t x);
		ctx_t            y;
		logic [1:0]      k;
		logic [2:0][7:0] copy;
		y = x;
		if (is_val(y.ph)) begin
			for (int it = 0; it < 4; it++) begin
				if (y.ph == PH_ESC) begin
					y = emit_b(y, CH_BSL);
					y.ph = PH_VALUE;
				end else if (y.ph == PH_HEX) begin
					k = (y.hc > 3'd3) ? 2'd3 : y.hc[1:0];
					copy = y.held;
					y.hc = '0;
					y.cp = '0;
					y.ph = PH_VALUE;
					for (int i = 0; i < 3; i++) begin
						if ((i < int'(k)) && is_val(y.ph)) begin
							y = value_byte(y, copy[i]);
						end
					end
				end
			end
			y.ph = PH_CLOSED;
		end else if (y.ph != PH_CLOSED) begin
			y.ph = PH_FAIL;
		end
		return y;
	endfunction

	function automatic ctx_t parse(input ctx_t x, input logic [7:0] c,
			input logic [6:0] key);
		ctx_t y;
		y = x;
		case (y.ph)
			PH_SRCH0: begin
				if (c == CH_QUOTE) begin
					y.ph = PH_SRCH1;
				end
			end
			PH_SRCH1: begin
				if (c == {1'b0, key}) begin
					y.ph = PH_SRCH2;
				end else if (c == CH_QUOTE) begin
					y.ph = PH_SRCH1;
				end else begin
					y.ph = PH_SRCH0;
				end
			end
			PH_SRCH2: begin
				y.ph = (c == CH_QUOTE) ? PH_PRECOLON : PH_SRCH0;
			end
			PH_PRECOLON: begin
				if (c == CH_COLON) begin
					y.ph = PH_POSTCOLON;
				end else if (!(c inside {CH_SPACE, CH_TAB})) begin
					y.ph = PH_FAIL;
				end
			end
			PH_POSTCOLON: begin
				if (c == CH_QUOTE) begin
					y.ph = PH_VALUE;
				end else if (!(c inside {CH_SPACE, CH_TAB})) begin
					y.ph = PH_FAIL;
				end
			end
			PH_VALUE, PH_ESC, PH_HEX: begin
				y = value_byte(y, c);
			end
			default: ;
		endcase
		return y;
	endfunction

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = !q_full;
	assign cfg_ready = 1'b1;

	always_comb begin
		cur.ph   = ph_q;
		cur.cp   = cp_q;
		cur.hc   = hc_q;
		cur.held = held_q;
		cur.ob   = '0;
		cur.on   = '0;
		if (s_tdata == 8'h00) begin
			body = end_buf(cur);
		end else begin
			body = parse(cur, s_tdata, key_q);
		end
		tail = end_buf(body);
		cnt_body = sat_add(cnt_q, body.on);
		cnt_tail = sat_add(cnt_q, tail.on);
	end

	always_comb begin
		if (s_tlast) begin
			cmd.data   = tail.ob;
			cmd.n_data = tail.on;
			cmd.stat   = 1'b1;
			cmd.kind   = (tail.ph == PH_CLOSED) ? jsfe_pkg::KIND_FOUND : jsfe_pkg::KIND_NONE;
			cmd.len    = jsfe_pkg::LEN_W'(cnt_tail);
		end else begin
			cmd.data   = body.ob;
			cmd.n_data = body.on;
			cmd.stat   = 1'b0;
			cmd.kind   = jsfe_pkg::KIND_DATA;
			cmd.len    = '0;
		end
	end

	assign cmd_valid = accept && ((body.on != '0) || s_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_SRCH0;
			cp_q  <= '0;
			hc_q  <= '0;
			cnt_q <= '0;
			key_q <= jsfe_pkg::KEY_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				key_q <= cfg_data;
			end
			if (accept) begin
				if (s_tlast) begin
					ph_q  <= PH_SRCH0;
					cp_q  <= '0;
					hc_q  <= '0;
					cnt_q <= '0;
				end else begin
					ph_q  <= body.ph;
					cp_q  <= body.cp;
					hc_q  <= body.hc;
					cnt_q <= cnt_body;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= body.held;
		end
	end

	// The line state is back at its start after a line closes.
	a_line_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> (ph_q == PH_SRCH0) && (cnt_q == '0))
		else $error("line state not cleared after end of line");

endmodule

[src/jsfe_queue.sv]
// ----------------------------------------------------------------------------
// jsfe_queue - command queue of the JSON string field extractor
// A small register FIFO between parser and result serializer.
// ----------------------------------------------------------------------------
module jsfe_queue #(
	parameter int DEPTH = jsfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jsfe_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output jsfe_pkg::cmd_t head,
	output logic           empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jsfe_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command pushed into a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue fill count beyond depth");

endmodule

[src/jsfe_back.sv]
// ----------------------------------------------------------------------------
// jsfe_back - result serializer of the JSON string field extractor
// Walks the command at the queue head and sends its data bytes and status
// one transfer at a time through a registered output.
// ----------------------------------------------------------------------------
module jsfe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  jsfe_pkg::cmd_t head,
	input  logic           empty,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [23:0]    m_tdata,
	output logic [1:0]     m_tuser,
	output logic           m_tlast
);

	logic                           vld_q;
	logic [jsfe_pkg::NW-1:0]        idx_q;
	logic [7:0]                     byte_q;
	logic [jsfe_pkg::LEN_W-1:0]     len_q;
	jsfe_pkg::kind_t                kind_q;
	logic                           last_q;

	logic load;
	logic take;
	logic is_data;
	logic done;

	always_comb begin
		load    = !vld_q || m_tready;
		take    = load && !empty;
		is_data = (idx_q < head.n_data);
		if (is_data) begin
			done = ((idx_q + jsfe_pkg::NW'(1)) == head.n_data) && !head.stat;
		end else begin
			done = 1'b1;
		end
		pop = take && done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (take) begin
			vld_q <= 1'b1;
			idx_q <= done ? '0 : idx_q + jsfe_pkg::NW'(1);
		end else if (load) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (is_data) begin
				byte_q <= head.data[idx_q[jsfe_pkg::SLOT_W-1:0]];
				len_q  <= '0;
				kind_q <= jsfe_pkg::KIND_DATA;
				last_q <= 1'b0;
			end else begin
				byte_q <= '0;
				len_q  <= head.len;
				kind_q <= head.kind;
				last_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {4'b0000, len_q, byte_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	// A status transfer never carries a data kind or a data byte.
	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && last_q) |-> (kind_q != jsfe_pkg::KIND_DATA) && (byte_q == 8'h00))
		else $error("malformed status transfer");

endmodule

[src/json_string_field_extractor.sv]
// ----------------------------------------------------------------------------
// json_string_field_extractor - top level
// Finds "k": "..." in a text line, where k is a configurable key character,
// and streams out the unescaped, UTF-8 encoded value followed by a status.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Signals                        Contents
// s_*       in         s_tvalid s_tready s_tdata      tdata[7:0] in_byte
//                      s_tlast                        tlast end_of_line
// m_*       out        m_tvalid m_tready m_tdata      tdata[7:0] out_byte,
//                      m_tuser m_tlast                [19:8] value_length
//                                                     tuser[1:0] result_kind
//                                                     tlast last_result
// cfg_*     in         cfg_valid cfg_ready cfg_data   [6:0] key_char
//
// The parser takes one input byte per cycle while the command queue has room;
// each byte causes zero to four result transfers (a status only on the last
// byte of a line). The serializer sends one result per cycle while m_tready
// is high, so the output port and the queue depth set the sustained rate: one
// byte per cycle as long as results average no more than one per byte. Results
// leave through an output register. Reset is asynchronous and clears the line
// state, the queue and the output register; the key returns to 'e'. Either
// side can stall on its own; the queue absorbs bursts in between.
// ----------------------------------------------------------------------------
module json_string_field_extractor #(
	parameter int MAX_LEN     = jsfe_pkg::MAX_LEN_DEF,
	parameter int QUEUE_DEPTH = jsfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Key character register write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,    // key_char
	// Line bytes in.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // in_byte
	input  logic        s_tlast,     // end_of_line
	// Results out.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,     // out_byte [7:0], value_length [19:8], zero fill
	output logic [1:0]  m_tuser,     // result_kind
	output logic        m_tlast      // last_result
);

	// Commands built by the parser for each transfer that produces results.
	logic           cmd_valid;
	jsfe_pkg::cmd_t cmd;

	// Queue status and head, as seen by the serializer.
	logic           q_full;
	logic           q_empty;
	logic           q_pop;
	jsfe_pkg::cmd_t q_head;

	// The parser owns the line state and the key register. It accepts a byte
	// whenever the queue is not full and never waits on the output side.
	jsfe_front #(
		.MAX_LEN (MAX_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	// The queue decouples the parser from output back pressure.
	jsfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_valid),
		.push_data (cmd),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	// The serializer splits each command into single result transfers and
	// pops it once the last of them has been loaded into the output register.
	jsfe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.empty    (q_empty),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

[bench/value_extract_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// value_extract_checker - result predictor and comparator
// Watches the key write channel, the line byte channel and the result
// channel, predicts the results of each accepted byte and compares them.
// ----------------------------------------------------------------------------
module value_extract_checker #(
	parameter int MAX_LEN = jsfe_pkg::MAX_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,     // out_byte [7:0], value_length [19:8], zero fill
	input  logic [1:0]  m_tuser,     // result_kind
	input  logic        m_tlast,
	output int          errors,
	output int          pending
);

	typedef enum logic [3:0] {
		SEEK_QUOTE, SEEK_KEY, SEEK_CLOSE, WANT_COLON, WANT_OPEN,
		IN_VALUE, IN_ESC, IN_HEX, DONE_CLOSED, DONE_FAIL
	} parse_t;

	typedef struct packed {
		logic [7:0]                 data;
		jsfe_pkg::kind_t            kind;
		logic [jsfe_pkg::LEN_W-1:0] len;
		logic                       last;
	} result_t;

	logic [6:0]  key;
	parse_t      ph;
	logic [15:0] cp;
	int          nhex;
	logic [7:0]  held [3];
	int          vcount;
	int          n_err;
	result_t     due_results [$];

	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return 4'(c - "0");
		if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
		if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
		return 4'd0;
	endfunction

	function automatic bit in_value();
		return ph == IN_VALUE || ph == IN_ESC || ph == IN_HEX;
	endfunction

	task automatic push_result(input logic [7:0] b, input jsfe_pkg::kind_t k,
			input int len, input logic last);
		result_t r;
		r.data = b;
		r.kind = k;
		r.len  = jsfe_pkg::LEN_W'(len);
		r.last = last;
		due_results.push_back(r);
	endtask

	task automatic push_data(input logic [7:0] b);
		push_result(b, jsfe_pkg::KIND_DATA, 0, 1'b0);
		if (vcount < MAX_LEN) vcount++;
		else vcount = MAX_LEN;
	endtask

	task automatic clear_line();
		ph     = SEEK_QUOTE;
		cp     = '0;
		nhex   = 0;
		held   = '{default: 8'h00};
		vcount = 0;
	endtask

	task automatic take_value_byte(input logic [7:0] c);
		case (ph)
			IN_VALUE: begin
				if (c == "\"") ph = DONE_CLOSED;
				else if (c == "\\") ph = IN_ESC;
				else push_data(c);
			end
			IN_ESC: begin
				ph = IN_VALUE;
				case (c)
					"n": push_data(8'h0A);
					"t": push_data(8'h09);
					"r": push_data(8'h0D);
					"b": push_data(8'h08);
					"f": push_data(8'h0C);
					"u": begin
						ph   = IN_HEX;
						cp   = '0;
						nhex = 0;
					end
					default: push_data(c);
				endcase
			end
			IN_HEX: begin
				if (nhex < 3) held[nhex] = c;
				cp = {cp[11:0], nibble_of(c)};
				nhex++;
				if (nhex >= 4) begin
					// One, two or three UTF-8 bytes depending on the code point.
					if (cp < 16'h0080) begin
						push_data(cp[7:0]);
					end else if (cp < 16'h0800) begin
						push_data({3'b110, cp[10:6]});
						push_data({2'b10, cp[5:0]});
					end else begin
						push_data({4'b1110, cp[15:12]});
						push_data({2'b10, cp[11:6]});
						push_data({2'b10, cp[5:0]});
					end
					nhex = 0;
					cp   = '0;
					ph   = IN_VALUE;
				end
			end
			default: ;
		endcase
	endtask

	// The buffer has ended: a pending backslash is emitted as is, and the
	// bytes held by an unfinished \u are replayed as ordinary value bytes.
	task automatic close_buffer();
		logic [7:0] saved [3];
		int n;
		int i;
		if (in_value()) begin
			while (ph == IN_ESC || ph == IN_HEX) begin
				if (ph == IN_ESC) begin
					push_data("\\");
					ph = IN_VALUE;
				end else begin
					n     = nhex > 3 ? 3 : nhex;
					saved = held;
					nhex  = 0;
					cp    = '0;
					ph    = IN_VALUE;
					for (i = 0; i < n && in_value(); i++) take_value_byte(saved[i]);
				end
			end
			ph = DONE_CLOSED;
		end else if (ph != DONE_CLOSED) begin
			ph = DONE_FAIL;
		end
	endtask

	task automatic parse_byte(input logic [7:0] c);
		case (ph)
			SEEK_QUOTE: if (c == "\"") ph = SEEK_KEY;
			SEEK_KEY: begin
				if (c == {1'b0, key}) ph = SEEK_CLOSE;
				else if (c == "\"") ph = SEEK_KEY;
				else ph = SEEK_QUOTE;
			end
			SEEK_CLOSE: ph = (c == "\"") ? WANT_COLON : SEEK_QUOTE;
			WANT_COLON: begin
				if (c == ":") ph = WANT_OPEN;
				else if (c != " " && c != "\t") ph = DONE_FAIL;
			end
			WANT_OPEN: begin
				if (c == "\"") ph = IN_VALUE;
				else if (c != " " && c != "\t") ph = DONE_FAIL;
			end
			IN_VALUE, IN_ESC, IN_HEX: take_value_byte(c);
			default: ;
		endcase
	endtask

	task automatic predict_byte(input logic [7:0] c, input logic eol);
		if (c == 8'h00) close_buffer();
		else parse_byte(c);
		if (eol) begin
			close_buffer();
			push_result(8'h00, ph == DONE_CLOSED ? jsfe_pkg::KIND_FOUND : jsfe_pkg::KIND_NONE,
				vcount, 1'b1);
			clear_line();
		end
	endtask

	task automatic check_result();
		result_t want;
		logic [23:0] want_tdata;
		if (due_results.size() == 0) begin
			n_err++;
			if (n_err <= 10)
				$display("%0t: unexpected result: tdata %h tuser %0d tlast %0b",
					$time, m_tdata, m_tuser, m_tlast);
			return;
		end
		want = due_results.pop_front();
		want_tdata = {4'b0000, want.len, want.data};
		if (m_tdata !== want_tdata || m_tuser !== want.kind || m_tlast !== want.last) begin
			n_err++;
			if (n_err <= 10)
				$display("%0t: mismatch: expected byte %h kind %0d len %0d last %0b, %s",
					$time, want.data, want.kind, want.len, want.last,
					$sformatf("got byte %h kind %0d len %0d last %0b fill %h",
					m_tdata[7:0], m_tuser, m_tdata[19:8], m_tlast, m_tdata[23:20]));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key = jsfe_pkg::KEY_RESET;
			clear_line();
			due_results.delete();
			n_err = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			// A result never comes from the byte accepted on the same edge,
			// so checking before predicting keeps the order intact.
			if (m_tvalid && m_tready) check_result();
			if (cfg_valid && cfg_ready) key = cfg_data;
			if (s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
			errors  <= n_err;
			pending <= due_results.size();
		end
	end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench for the JSON string field extractor
// Feeds text lines, directed and random, under several key characters with
// idle cycles on both sides, and lets the checker compare every result.
// ----------------------------------------------------------------------------
module tb;

	localparam int MAX_LEN     = jsfe_pkg::MAX_LEN_DEF;
	// Cycles the receiver holds off in the pressure phase.
	localparam int HOLD_CYCLES = 300;
	// Cycles without any transfer before the run is declared hung.
	localparam int STALL_LIMIT = 3000;
	// Input bytes per random phase.
	localparam int PHASE_BYTES = 55;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data  = jsfe_pkg::KEY_RESET;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int n_errors;
	int n_due;

	// Shared between the sender and the receiver processes.
	bit gaps_on  = 1'b0;
	bit hold_req = 1'b0;

	logic [6:0] cur_key = jsfe_pkg::KEY_RESET;
	logic [7:0] line_buf [$];
	int         phase_bytes;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	json_string_field_extractor #(
		.MAX_LEN (MAX_LEN)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	value_extract_checker #(
		.MAX_LEN (MAX_LEN)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.errors    (n_errors),
		.pending   (n_due)
	);

	// ------------------------------------------------------------------------
	// Result receiver. Normally it stalls now and then at random. When the
	// sender raises hold_req it holds off for a long stretch, counted here,
	// while the sender keeps offering bytes, so the queue inside the block
	// fills up and the input side has to stall as well.
	// ------------------------------------------------------------------------
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				m_tready <= 1'b1;
			end else if (gaps_on && $urandom_range(99) < 6) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog. Any transfer on any channel restarts the count; a block that
	// stops moving, or a result that never comes, ends the run as a failure.
	// ------------------------------------------------------------------------
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: done, errors");
		$finish;
	end

	// Offers one byte and returns once the transfer has happened. Before the
	// byte the sender may idle for a cycle.
	task automatic offer_byte(input logic [7:0] b, input logic last);
		if (gaps_on && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	// Sends the collected line, marking its final byte with tlast.
	task automatic send_line();
		int i;
		for (i = 0; i < line_buf.size(); i++)
			offer_byte(line_buf[i], i == line_buf.size() - 1);
		phase_bytes += line_buf.size();
		line_buf.delete();
	endtask

	// Stops sending and waits until every predicted result has arrived. A
	// byte that causes no result can still be in flight then, so the task
	// does not return at once.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (n_due != 0);
		repeat (8) @(posedge clk);
	endtask

	// Only called with the block idle, between lines.
	task automatic write_key(input logic [6:0] k);
		cfg_valid <= 1'b1;
		cfg_data  <= k;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_key = k;
	endtask

	task automatic put_str(input string s);
		int i;
		for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endtask

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		c = 8'($urandom_range(32, 126));
		if (c == "\"" || c == "\\") c = "a";
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 10) return "0" + 8'(n);
		if ($urandom_range(1)) return "A" + 8'(n) - 8'd10;
		return "a" + 8'(n) - 8'd10;
	endfunction

	task automatic put_ws();
		repeat ($urandom_range(0, 2)) line_buf.push_back($urandom_range(1) ? " " : "\t");
	endtask

	// Opening of a key/value pair, with some noise in front. When broken,
	// the colon or the opening quote of the value is replaced by junk.
	task automatic put_header(input bit broken);
		int which;
		which = $urandom_range(1);
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(3) == 0) begin
				// A quoted decoy that may or may not be the key.
				line_buf.push_back("\"");
				line_buf.push_back(plain_char());
			end else begin
				line_buf.push_back(plain_char());
			end
		end
		line_buf.push_back("\"");
		line_buf.push_back({1'b0, cur_key});
		line_buf.push_back("\"");
		put_ws();
		line_buf.push_back(broken && which == 0 ? plain_char() : ":");
		put_ws();
		line_buf.push_back(broken && which == 1 ? plain_char() : "\"");
	endtask

	// One piece of value text: a plain byte, a simple escape, an escape of
	// some other byte, or a \u escape reaching all three UTF-8 lengths.
	task automatic put_value_piece();
		string esc_set;
		logic [15:0] code;
		int r;
		int k;
		esc_set = "ntrbf\"\\/";
		r = $urandom_range(99);
		if (r < 55) begin
			line_buf.push_back(plain_char());
		end else if (r < 62) begin
			line_buf.push_back(8'($urandom_range(128, 255)));
		end else if (r < 82) begin
			line_buf.push_back("\\");
			if ($urandom_range(4) == 0) line_buf.push_back(8'($urandom_range(1, 255)));
			else line_buf.push_back(esc_set[$urandom_range(7)]);
		end else begin
			case ($urandom_range(2))
				0: code = 16'($urandom_range(16'h0000, 16'h007F));
				1: code = 16'($urandom_range(16'h0080, 16'h07FF));
				default: code = 16'($urandom_range(16'h0800, 16'hFFFF));
			endcase
			line_buf.push_back("\\");
			line_buf.push_back("u");
			// Now and then one digit is not hex and counts as zero.
			k = $urandom_range(9) == 0 ? $urandom_range(3) : 4;
			for (int i = 3; i >= 0; i--)
				line_buf.push_back(i == k ? "g" : hex_char(code[i*4 +: 4]));
		end
	endtask

	// One random line: mostly a well-formed pair with random content and a
	// random ending, else a broken header or plain noise.
	task automatic random_line();
		string tail_set;
		int r;
		int e;
		tail_set = "0aF\\\"un";
		r = $urandom_range(99);
		if (r < 75) begin
			put_header(1'b0);
			repeat ($urandom_range(0, 8)) put_value_piece();
			e = $urandom_range(99);
			if (e < 70) begin
				line_buf.push_back("\"");
				repeat ($urandom_range(0, 3))
					line_buf.push_back($urandom_range(3) == 0 ? "\"" : plain_char());
			end else if (e < 92 && e >= 80) begin
				// The line ends inside an escape; a short \u may hold
				// bytes that are escapes or quotes themselves.
				line_buf.push_back("\\");
				if ($urandom_range(3) != 0) begin
					line_buf.push_back("u");
					repeat ($urandom_range(0, 3))
						line_buf.push_back(tail_set[$urandom_range(tail_set.len() - 1)]);
				end
			end else if (e >= 92) begin
				line_buf.push_back(8'h00);
				repeat ($urandom_range(0, 3)) line_buf.push_back(8'($urandom_range(255)));
			end
		end else if (r < 87) begin
			put_header(1'b1);
			repeat ($urandom_range(0, 4)) put_value_piece();
		end else begin
			repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(255)));
		end
		send_line();
	endtask

	// ------------------------------------------------------------------------
	// Stimulus. Reset once, a directed part under the reset key, then random
	// phases under several keys: the printable extremes, a quote as the key,
	// a key with bit 5 clear, two random ones and the reset key again. Each
	// phase ends with a pause until every predicted result has come, which
	// is also the only time the key is rewritten.
	// ------------------------------------------------------------------------
	initial begin
		logic [6:0] keys [7];
		int p;
		keys = '{7'd126, 7'd32, 7'd34, 7'd75, 7'd0, 7'd0, jsfe_pkg::KEY_RESET};
		keys[4] = 7'($urandom_range(32, 126));
		keys[5] = 7'($urandom_range(32, 126));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A \u cut short by the end of the line: its held digit is replayed.
		put_str("\"e\":\"\\u4");
		send_line();
		// Wrong punctuation after the key fails the line.
		put_str("\"e\"x");
		send_line();
		// A backslash as the final byte is emitted literally.
		put_str("\"e\":\"\\");
		send_line();
		// A zero byte ends the buffer; the byte after it is ignored.
		line_buf.push_back(8'h00);
		line_buf.push_back(8'hFF);
		send_line();
		wait_drained();

		for (p = 0; p < 7; p++) begin
			write_key(keys[p]);
			// One phase runs with no idling at all on either side.
			gaps_on = (p != 3);
			// In the second phase the receiver holds off for a long time.
			if (p == 1) hold_req = 1'b1;
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) random_line();
			wait_drained();
		end

		if (n_errors == 0 && n_due == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
